// ===== src/lbtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbtc_pkg: shared definitions for the LRU block translation cache
// Field widths, block geometry, controller states and the write-enable
// group of the slot table.
// ----------------------------------------------------------------------------
package lbtc_pkg;

  // Block geometry: the source space is cut into blocks of 2^BLOCK_BITS bytes.
  localparam int BLOCK_BITS  = 16;
  localparam int BLOCK_COUNT = 1024;
  localparam int BLK_W       = $clog2(BLOCK_COUNT);

  // Default number of slots.
  localparam int SLOT_COUNT_DEF = 512;

  // Port widths.
  localparam int IN_W   = 26;
  localparam int ADDR_W = 25;
  localparam int CFG_W  = 10;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_SLOT,
    ST_PV,
    ST_NX,
    ST_TAIL,
    ST_DONE
  } lbtc_state_e;

  // Field write enables of one slot table entry.
  typedef struct packed {
    logic owner;
    logic prev;
    logic next;
  } lbtc_slot_wen_t;

endpackage

// ===== src/lbtc_map_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbtc_map_mem: block map memory
// One entry per block, holding the slot the block was last mapped to.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbtc_map_mem
  import lbtc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int SLOT_W = $clog2(SLOT_COUNT)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [BLK_W-1:0]  waddr_i,
  input  logic [SLOT_W-1:0] wdata_i,
  input  logic [BLK_W-1:0]  raddr_i,
  output logic [SLOT_W-1:0] rdata_o
);

  logic [SLOT_W-1:0] mem_q [BLOCK_COUNT];
  logic [SLOT_W-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lbtc_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbtc_slot_mem: slot table memory
// One entry per slot: owner valid bit, owner block and the two links of the
// replacement list. One write port with field enables, two read ports with
// registered read data.
// ----------------------------------------------------------------------------
module lbtc_slot_mem
  import lbtc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int SLOT_W = $clog2(SLOT_COUNT),
  localparam int LINK_W = SLOT_W + 1
) (
  input  logic              clk_i,
  input  lbtc_slot_wen_t    wen_i,
  input  logic [SLOT_W-1:0] waddr_i,
  input  logic              wvalid_i,
  input  logic [BLK_W-1:0]  wowner_i,
  input  logic [LINK_W-1:0] wprev_i,
  input  logic [LINK_W-1:0] wnext_i,
  input  logic [SLOT_W-1:0] raddr_a_i,
  output logic              rd_a_valid_o,
  output logic [BLK_W-1:0]  rd_a_owner_o,
  output logic [LINK_W-1:0] rd_a_prev_o,
  output logic [LINK_W-1:0] rd_a_next_o,
  input  logic [SLOT_W-1:0] raddr_b_i,
  output logic              rd_b_valid_o,
  output logic [BLK_W-1:0]  rd_b_owner_o,
  output logic [LINK_W-1:0] rd_b_prev_o,
  output logic [LINK_W-1:0] rd_b_next_o
);

  typedef struct packed {
    logic              valid;
    logic [BLK_W-1:0]  owner;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] next;
  } entry_t;

  entry_t mem_q [SLOT_COUNT];
  entry_t rd_a_q;
  entry_t rd_b_q;

  // Field-wise write and two registered reads.
  always_ff @(posedge clk_i) begin
    if (wen_i.owner) begin
      mem_q[waddr_i].valid <= wvalid_i;
      mem_q[waddr_i].owner <= wowner_i;
    end
    if (wen_i.prev) begin
      mem_q[waddr_i].prev <= wprev_i;
    end
    if (wen_i.next) begin
      mem_q[waddr_i].next <= wnext_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rd_a_valid_o = rd_a_q.valid;
  assign rd_a_owner_o = rd_a_q.owner;
  assign rd_a_prev_o  = rd_a_q.prev;
  assign rd_a_next_o  = rd_a_q.next;
  assign rd_b_valid_o = rd_b_q.valid;
  assign rd_b_owner_o = rd_b_q.owner;
  assign rd_b_prev_o  = rd_b_q.prev;
  assign rd_b_next_o  = rd_b_q.next;

endmodule

// ===== src/lbtc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbtc_ctrl: lookup and replacement sequencer
// Sweeps both memories after reset or a slot count write, then per item reads
// the block map and the slot table, decides hit or miss, and writes back the
// owner, the map entry and the list links, one slot table write at a time.
// ----------------------------------------------------------------------------
module lbtc_ctrl
  import lbtc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int SLOT_W = $clog2(SLOT_COUNT),
  localparam int LINK_W = SLOT_W + 1,
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              cfg_wr_i,
  // Input item
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [IN_W-1:0]   in_byte_offset_i,
  // Finished result
  output logic              res_valid_o,
  input  logic              res_take_i,
  output logic [ADDR_W-1:0] res_mapped_address_o,
  output logic              res_miss_o,
  output logic [BLK_W-1:0]  res_fill_block_o,
  output logic              res_evicted_valid_o,
  output logic [BLK_W-1:0]  res_evicted_block_o,
  // Block map memory
  output logic              map_we_o,
  output logic [BLK_W-1:0]  map_waddr_o,
  output logic [SLOT_W-1:0] map_wdata_o,
  output logic [BLK_W-1:0]  map_raddr_o,
  input  logic [SLOT_W-1:0] map_rdata_i,
  // Slot table memory
  output lbtc_slot_wen_t    slot_wen_o,
  output logic [SLOT_W-1:0] slot_waddr_o,
  output logic              slot_wvalid_o,
  output logic [BLK_W-1:0]  slot_wowner_o,
  output logic [LINK_W-1:0] slot_wprev_o,
  output logic [LINK_W-1:0] slot_wnext_o,
  output logic [SLOT_W-1:0] slot_raddr_a_o,
  input  logic              rd_a_valid_i,
  input  logic [BLK_W-1:0]  rd_a_owner_i,
  input  logic [LINK_W-1:0] rd_a_prev_i,
  input  logic [LINK_W-1:0] rd_a_next_i,
  output logic [SLOT_W-1:0] slot_raddr_b_o,
  input  logic              rd_b_valid_i,
  input  logic [BLK_W-1:0]  rd_b_owner_i,
  input  logic [LINK_W-1:0] rd_b_prev_i,
  input  logic [LINK_W-1:0] rd_b_next_i
);

  // A link with its top bit set points nowhere.
  localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {SLOT_W{1'b0}}};

  lbtc_state_e state_q, state_d;

  logic [BLK_W-1:0]      clr_cnt_q, clr_cnt_d;
  logic [SLOT_W-1:0]     head_q, head_d;
  logic [SLOT_W-1:0]     tail_q, tail_d;
  logic [BLK_W-1:0]      blk_q, blk_d;
  logic [BLOCK_BITS-1:0] low_q, low_d;
  logic [SLOT_W-1:0]     sm_q, sm_d;
  logic [SLOT_W-1:0]     s_q, s_d;
  logic [LINK_W-1:0]     pv_q, pv_d;
  logic [LINK_W-1:0]     nx_q, nx_d;
  logic                  miss_q, miss_d;
  logic                  evv_q, evv_d;
  logic [BLK_W-1:0]      evb_q, evb_d;

  logic              hit;
  logic [SLOT_W-1:0] sel_s;
  logic [LINK_W-1:0] sel_pv;
  logic [LINK_W-1:0] sel_nx;
  logic [BLK_W:0]    clr_next_idx;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
    end
  end

  // Item registers.
  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    low_q  <= low_d;
    sm_q   <= sm_d;
    s_q    <= s_d;
    pv_q   <= pv_d;
    nx_q   <= nx_d;
    miss_q <= miss_d;
    evv_q  <= evv_d;
    evb_q  <= evb_d;
  end

  // Hit check: the mapped slot is in use and still owned by this block.
  assign hit    = (CNT_W'(sm_q) < count_i) && rd_a_valid_i && (rd_a_owner_i == blk_q);
  assign sel_s  = hit ? sm_q : head_q;
  assign sel_pv = hit ? rd_a_prev_i : rd_b_prev_i;
  assign sel_nx = hit ? rd_a_next_i : rd_b_next_i;

  assign clr_next_idx = (BLK_W + 1)'(clr_cnt_q) + 1'b1;

  // Next state, memory accesses and list updates.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    head_d    = head_q;
    tail_d    = tail_q;
    blk_d     = blk_q;
    low_d     = low_q;
    sm_d      = sm_q;
    s_d       = s_q;
    pv_d      = pv_q;
    nx_d      = nx_q;
    miss_d    = miss_q;
    evv_d     = evv_q;
    evb_d     = evb_q;

    map_we_o       = 1'b0;
    map_waddr_o    = blk_q;
    map_wdata_o    = sel_s;
    map_raddr_o    = in_byte_offset_i[BLOCK_BITS +: BLK_W];
    slot_wen_o     = '0;
    slot_waddr_o   = s_q;
    slot_wvalid_o  = 1'b1;
    slot_wowner_o  = blk_q;
    slot_wprev_o   = {1'b0, tail_q};
    slot_wnext_o   = LINK_NONE;
    slot_raddr_a_o = map_rdata_i;
    slot_raddr_b_o = head_q;
    res_valid_o    = 1'b0;

    unique case (state_q)
      // Clearing pass: map entries to zero, slot entries to the initial list.
      ST_CLEAR: begin
        map_we_o      = 1'b1;
        map_waddr_o   = clr_cnt_q;
        map_wdata_o   = '0;
        slot_waddr_o  = clr_cnt_q[SLOT_W-1:0];
        slot_wvalid_o = 1'b0;
        slot_wowner_o = '0;
        slot_wprev_o  = (clr_cnt_q == '0) ? LINK_NONE
                                          : {1'b0, SLOT_W'(clr_cnt_q - 1'b1)};
        slot_wnext_o  = (clr_next_idx >= (BLK_W + 1)'(count_i)) ? LINK_NONE
                                          : {1'b0, SLOT_W'(clr_next_idx)};
        if (clr_cnt_q < BLK_W'(SLOT_COUNT)) begin
          slot_wen_o = '{owner: 1'b1, prev: 1'b1, next: 1'b1};
        end
        head_d    = '0;
        tail_d    = SLOT_W'(count_i - 1'b1);
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == BLK_W'(BLOCK_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      // Accept an item; the map read is issued in the same cycle.
      ST_IDLE: begin
        if (in_valid_i) begin
          blk_d   = in_byte_offset_i[BLOCK_BITS +: BLK_W];
          low_d   = in_byte_offset_i[BLOCK_BITS-1:0];
          state_d = ST_MAP;
        end
      end
      // Map data back: read the mapped slot and the list head.
      ST_MAP: begin
        sm_d    = map_rdata_i;
        state_d = ST_SLOT;
      end
      // Decide, take over the slot on a miss and detach it from the list.
      ST_SLOT: begin
        s_d    = sel_s;
        pv_d   = sel_pv;
        nx_d   = sel_nx;
        miss_d = !hit;
        evv_d  = !hit && rd_b_valid_i;
        evb_d  = (!hit && rd_b_valid_i) ? rd_b_owner_i : '0;
        slot_waddr_o = sel_s;
        if (!hit) begin
          slot_wen_o.owner = 1'b1;
          map_we_o         = 1'b1;
        end
        if (sel_nx[SLOT_W]) begin
          // Already the most recently used slot.
          state_d = ST_DONE;
        end else begin
          slot_wen_o.prev = 1'b1;
          slot_wen_o.next = 1'b1;
          if (sel_pv[SLOT_W]) begin
            head_d  = sel_nx[SLOT_W-1:0];
            state_d = ST_NX;
          end else begin
            state_d = ST_PV;
          end
        end
      end
      // Predecessor skips over the moved slot.
      ST_PV: begin
        slot_wen_o.next = 1'b1;
        slot_waddr_o    = pv_q[SLOT_W-1:0];
        slot_wnext_o    = nx_q;
        state_d         = ST_NX;
      end
      // Successor points back to the predecessor.
      ST_NX: begin
        slot_wen_o.prev = 1'b1;
        slot_waddr_o    = nx_q[SLOT_W-1:0];
        slot_wprev_o    = pv_q;
        state_d         = ST_TAIL;
      end
      // Old tail links forward to the moved slot, which becomes the tail.
      ST_TAIL: begin
        slot_wen_o.next = 1'b1;
        slot_waddr_o    = tail_q;
        slot_wnext_o    = {1'b0, s_q};
        tail_d          = s_q;
        state_d         = ST_DONE;
      end
      // Hand the result to the output register.
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase

    // A slot count write restarts the clearing pass.
    if (cfg_wr_i) begin
      state_d   = ST_CLEAR;
      clr_cnt_d = '0;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Result fields.
  assign res_mapped_address_o = (ADDR_W'(s_q) << BLOCK_BITS) | ADDR_W'(low_q);
  assign res_miss_o           = miss_q;
  assign res_fill_block_o     = miss_q ? blk_q : '0;
  assign res_evicted_valid_o  = evv_q;
  assign res_evicted_block_o  = evb_q;

endmodule

// ===== src/lru_block_translation_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_translation_cache: fully associative LRU block translation cache
// Maps a byte offset in a block-organized space to a slot-relative address,
// replacing the least recently used slot on a miss.
// ----------------------------------------------------------------------------
// One item is in work at a time: the next item is accepted only after the
// result of the last one has gone into the output register. When the item's
// slot is already the most recently used one, its result follows the slot
// table read directly. Otherwise the slot table's single write port sets the
// order of the updates: the moved slot's links, and on a miss its owner, go in
// one write, then the predecessor (absent for the list head), the successor
// and the old tail each take one more write. A result waits while the output
// register holds an earlier item that is stalled, and the next item waits
// with it. After reset and after every slot count write the block runs a
// clearing pass over all BLOCK_COUNT (1024) block map entries and the slot
// table, during which in_stall_o is high; slot count writes are always taken.
// A miss reports the block to fill and, when a previously cached block lost
// its slot, that block.
// ----------------------------------------------------------------------------
module lru_block_translation_cache
  import lbtc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Slot count register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_slot_count_i,
  // Input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [IN_W-1:0]   in_byte_offset_i,
  // Result items
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ADDR_W-1:0] out_mapped_address_o,
  output logic              out_miss_o,
  output logic [BLK_W-1:0]  out_fill_block_o,
  output logic              out_evicted_valid_o,
  output logic [BLK_W-1:0]  out_evicted_block_o
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int LINK_W = SLOT_W + 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             cfg_wr;

  logic              res_valid;
  logic              res_take;
  logic [ADDR_W-1:0] res_mapped_address;
  logic              res_miss;
  logic [BLK_W-1:0]  res_fill_block;
  logic              res_evicted_valid;
  logic [BLK_W-1:0]  res_evicted_block;

  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_mapped_address_q;
  logic              out_miss_q;
  logic [BLK_W-1:0]  out_fill_block_q;
  logic              out_evicted_valid_q;
  logic [BLK_W-1:0]  out_evicted_block_q;

  logic              map_we;
  logic [BLK_W-1:0]  map_waddr;
  logic [SLOT_W-1:0] map_wdata;
  logic [BLK_W-1:0]  map_raddr;
  logic [SLOT_W-1:0] map_rdata;

  lbtc_slot_wen_t    slot_wen;
  logic [SLOT_W-1:0] slot_waddr;
  logic              slot_wvalid;
  logic [BLK_W-1:0]  slot_wowner;
  logic [LINK_W-1:0] slot_wprev;
  logic [LINK_W-1:0] slot_wnext;
  logic [SLOT_W-1:0] slot_raddr_a;
  logic              rd_a_valid;
  logic [BLK_W-1:0]  rd_a_owner;
  logic [LINK_W-1:0] rd_a_prev;
  logic [LINK_W-1:0] rd_a_next;
  logic [SLOT_W-1:0] slot_raddr_b;
  logic              rd_b_valid;
  logic [BLK_W-1:0]  rd_b_owner;
  logic [LINK_W-1:0] rd_b_prev;
  logic [LINK_W-1:0] rd_b_next;

  // Slot count register, clamped to one through SLOT_COUNT.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    count_d = count_q;
    if (cfg_wr) begin
      if (cfg_slot_count_i == '0) begin
        count_d = CNT_W'(1);
      end else if (cfg_slot_count_i > CFG_W'(SLOT_COUNT)) begin
        count_d = CNT_W'(SLOT_COUNT);
      end else begin
        count_d = CNT_W'(cfg_slot_count_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(SLOT_COUNT);
    end else begin
      count_q <= count_d;
    end
  end

  // Sequencer.
  lbtc_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .count_i              (count_q),
    .cfg_wr_i             (cfg_wr),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_byte_offset_i     (in_byte_offset_i),
    .res_valid_o          (res_valid),
    .res_take_i           (res_take),
    .res_mapped_address_o (res_mapped_address),
    .res_miss_o           (res_miss),
    .res_fill_block_o     (res_fill_block),
    .res_evicted_valid_o  (res_evicted_valid),
    .res_evicted_block_o  (res_evicted_block),
    .map_we_o             (map_we),
    .map_waddr_o          (map_waddr),
    .map_wdata_o          (map_wdata),
    .map_raddr_o          (map_raddr),
    .map_rdata_i          (map_rdata),
    .slot_wen_o           (slot_wen),
    .slot_waddr_o         (slot_waddr),
    .slot_wvalid_o        (slot_wvalid),
    .slot_wowner_o        (slot_wowner),
    .slot_wprev_o         (slot_wprev),
    .slot_wnext_o         (slot_wnext),
    .slot_raddr_a_o       (slot_raddr_a),
    .rd_a_valid_i         (rd_a_valid),
    .rd_a_owner_i         (rd_a_owner),
    .rd_a_prev_i          (rd_a_prev),
    .rd_a_next_i          (rd_a_next),
    .slot_raddr_b_o       (slot_raddr_b),
    .rd_b_valid_i         (rd_b_valid),
    .rd_b_owner_i         (rd_b_owner),
    .rd_b_prev_i          (rd_b_prev),
    .rd_b_next_i          (rd_b_next)
  );

  // Block map.
  lbtc_map_mem #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_map_mem (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Slot owners and replacement list.
  lbtc_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_mem (
    .clk_i        (clk_i),
    .wen_i        (slot_wen),
    .waddr_i      (slot_waddr),
    .wvalid_i     (slot_wvalid),
    .wowner_i     (slot_wowner),
    .wprev_i      (slot_wprev),
    .wnext_i      (slot_wnext),
    .raddr_a_i    (slot_raddr_a),
    .rd_a_valid_o (rd_a_valid),
    .rd_a_owner_o (rd_a_owner),
    .rd_a_prev_o  (rd_a_prev),
    .rd_a_next_o  (rd_a_next),
    .raddr_b_i    (slot_raddr_b),
    .rd_b_valid_o (rd_b_valid),
    .rd_b_owner_o (rd_b_owner),
    .rd_b_prev_o  (rd_b_prev),
    .rd_b_next_o  (rd_b_next)
  );

  // Output register: loads when empty or when its item is being taken.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_mapped_address_q <= res_mapped_address;
      out_miss_q           <= res_miss;
      out_fill_block_q     <= res_fill_block;
      out_evicted_valid_q  <= res_evicted_valid;
      out_evicted_block_q  <= res_evicted_block;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_mapped_address_o = out_mapped_address_q;
  assign out_miss_o           = out_miss_q;
  assign out_fill_block_o     = out_fill_block_q;
  assign out_evicted_valid_o  = out_evicted_valid_q;
  assign out_evicted_block_o  = out_evicted_block_q;

  // Only one item is in work: an accepted item stalls the input next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in work");

  // A slot count write starts the clearing pass, which stalls the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> in_stall_o)
    else $error("input not stalled after a slot count write");

  // Every result names a slot that is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CNT_W'(out_mapped_address_o[ADDR_W-1:BLOCK_BITS]) < count_q))
    else $error("result slot beyond the slot count");

endmodule

// ===== tb/sv/lru_block_translation_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_translation_cache_tb: self-checking bench for the LRU block cache
// Sends byte offsets through the input channel and predicts each slot-relative
// address, miss flag, fill block and evicted block with an LRU model. The run
// goes through several slot count settings. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module lru_block_translation_cache_tb;
  import lbtc_pkg::*;

  localparam int          SLOTS_MAX     = SLOT_COUNT_DEF;
  localparam logic [BLK_W-1:0] NOT_CACHED = 10'h200;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          TAIL_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          PHASES        = 8;

  // One expected translation result.
  typedef struct packed {
    logic [ADDR_W-1:0] mapped_address;
    logic              miss;
    logic [BLK_W-1:0]  fill_block;
    logic              evicted_valid;
    logic [BLK_W-1:0]  evicted_block;
  } xlat_result_t;

  // Tracks the block map and LRU order and holds the pending translations.
  class lbtc_scoreboard;
    logic [BLK_W-1:0] slot_of_block [BLOCK_COUNT];
    bit               owned         [SLOTS_MAX];
    logic [BLK_W-1:0] owner_of      [SLOTS_MAX];
    logic [BLK_W-1:0] prev_link     [SLOTS_MAX];
    logic [BLK_W-1:0] next_link     [SLOTS_MAX];
    int unsigned      lru_slot;
    int unsigned      mru_slot;
    int unsigned      slots_in_use;
    xlat_result_t     expected_q [$];
    int unsigned      error_count;
    int unsigned      checked_count;
    int unsigned      miss_count;
    int unsigned      evict_count;

    function new();
      error_count   = 0;
      checked_count = 0;
      miss_count    = 0;
      evict_count   = 0;
      set_slot_count(SLOT_COUNT_DEF);
    endfunction

    // A slot count write flushes every mapping and restores slot order.
    function void set_slot_count(int unsigned value);
      int unsigned cnt;
      cnt = value;
      if (cnt < 1) cnt = 1;
      if (cnt > SLOTS_MAX) cnt = SLOTS_MAX;
      slots_in_use = cnt;
      foreach (slot_of_block[b]) slot_of_block[b] = NOT_CACHED;
      for (int s = 0; s < SLOTS_MAX; s++) begin
        owned[s]     = 1'b0;
        owner_of[s]  = '0;
        prev_link[s] = (s == 0) ? NOT_CACHED : BLK_W'(s - 1);
        next_link[s] = (s + 1 >= cnt) ? NOT_CACHED : BLK_W'(s + 1);
      end
      lru_slot = 0;
      mru_slot = cnt - 1;
    endfunction

    // Unlink a slot and append it at the most recently used end.
    function void move_to_mru(int unsigned s);
      int unsigned nx;
      int unsigned pv;
      nx = next_link[s];
      pv = prev_link[s];
      if (nx >= SLOTS_MAX) return;
      if (pv < SLOTS_MAX) begin
        next_link[pv] = BLK_W'(nx);
        prev_link[nx] = BLK_W'(pv);
      end else begin
        lru_slot      = nx;
        prev_link[nx] = NOT_CACHED;
      end
      prev_link[s] = BLK_W'(mru_slot);
      next_link[s] = NOT_CACHED;
      if (mru_slot < SLOTS_MAX) next_link[mru_slot] = BLK_W'(s);
      mru_slot = s;
    endfunction

    // Translate one accepted offset and queue the result it must produce.
    function void note_offset(logic [IN_W-1:0] offset);
      int unsigned  blk;
      int unsigned  s;
      int unsigned  old;
      xlat_result_t want;
      blk  = offset[IN_W-1:BLOCK_BITS] % BLOCK_COUNT;
      s    = slot_of_block[blk];
      want = '0;
      if (s >= slots_in_use) begin
        s = lru_slot;
        if (s >= SLOTS_MAX) s = 0;
        want.miss       = 1'b1;
        want.fill_block = BLK_W'(blk);
        miss_count++;
        if (owned[s]) begin
          old                 = owner_of[s] % BLOCK_COUNT;
          slot_of_block[old]  = NOT_CACHED;
          want.evicted_valid  = 1'b1;
          want.evicted_block  = BLK_W'(old);
          evict_count++;
        end
        owned[s]           = 1'b1;
        owner_of[s]        = BLK_W'(blk);
        slot_of_block[blk] = BLK_W'(s);
      end
      move_to_mru(s);
      want.mapped_address = ADDR_W'((s << BLOCK_BITS) | offset[BLOCK_BITS-1:0]);
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
    endtask

    // Compare one delivered result with the oldest pending translation.
    task check_result(xlat_result_t got);
      xlat_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, address %h", got.mapped_address));
        return;
      end
      want = expected_q.pop_front();
      checked_count++;
      if (got.mapped_address !== want.mapped_address)
        report_mismatch($sformatf("mapped_address %h, want %h",
                                  got.mapped_address, want.mapped_address));
      if (got.miss !== want.miss)
        report_mismatch($sformatf("miss %b, want %b", got.miss, want.miss));
      if (got.fill_block !== want.fill_block)
        report_mismatch($sformatf("fill_block %0d, want %0d",
                                  got.fill_block, want.fill_block));
      if (got.evicted_valid !== want.evicted_valid)
        report_mismatch($sformatf("evicted_valid %b, want %b",
                                  got.evicted_valid, want.evicted_valid));
      if (got.evicted_block !== want.evicted_block)
        report_mismatch($sformatf("evicted_block %0d, want %0d",
                                  got.evicted_block, want.evicted_block));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_slot_count_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [IN_W-1:0]   in_byte_offset_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ADDR_W-1:0] out_mapped_address_o;
  logic              out_miss_o;
  logic [BLK_W-1:0]  out_fill_block_o;
  logic              out_evicted_valid_o;
  logic [BLK_W-1:0]  out_evicted_block_o;

  lbtc_scoreboard sb;
  int unsigned    items_sent;
  int unsigned    settings_done;
  int unsigned    stall_left;
  int unsigned    cycle_count;
  bit             send_calm;
  bit             recv_calm;

  lru_block_translation_cache i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_slot_count_i     (cfg_slot_count_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_byte_offset_i     (in_byte_offset_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_mapped_address_o (out_mapped_address_o),
    .out_miss_o           (out_miss_o),
    .out_fill_block_o     (out_fill_block_o),
    .out_evicted_valid_o  (out_evicted_valid_o),
    .out_evicted_block_o  (out_evicted_block_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // All inputs start known while reset is held low, then reset is released.
  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_slot_count_i = '0;
    in_valid_i       = 1'b0;
    in_byte_offset_i = '0;
    out_stall_i      = 1'b0;
    stall_left       = 0;
    recv_calm        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Guard against a hung handshake.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, sb.expected_q.size());
      $display("lru_block_translation_cache_tb: done, errors");
      $finish;
    end
  end

  // Result side stall: counts down only while a result is being offered.
  always @(negedge clk_i) begin
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0 && out_valid_o) stall_left = stall_left - 1;
  end

  // Check every accepted result and draw the stall for the next one.
  always @(posedge clk_i) begin
    xlat_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.mapped_address = out_mapped_address_o;
      got.miss           = out_miss_o;
      got.fill_block     = out_fill_block_o;
      got.evicted_valid  = out_evicted_valid_o;
      got.evicted_block  = out_evicted_block_o;
      sb.check_result(got);
      if (sb.checked_count % 32 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      stall_left = recv_calm ? 0 : $urandom_range(0, 13);
    end
  end

  // Offer one item after a random gap and wait until it is taken.
  task automatic send_item(input logic [IN_W-1:0] offset);
    int unsigned gap;
    if (items_sent % 32 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_byte_offset_i <= offset;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_offset(offset);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Write the slot count once the cache has drained.
  task automatic write_slot_count(input logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_slot_count_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_slot_count(value);
    settings_done++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [IN_W-1:0]  directed_q [$];
    logic [IN_W-1:0]  single_q [$];
    logic [CFG_W-1:0] plan_value [PHASES];
    int unsigned      plan_items [PHASES];
    int unsigned      eff;
    int unsigned      pool_base;
    int unsigned      pool_size;
    int unsigned      stream_blk;
    int unsigned      blk;
    logic [15:0]      low;
    logic [IN_W-1:0]  offset;

    sb            = new();
    items_sent    = 0;
    settings_done = 0;
    send_calm     = 1'b0;

    // Extremes of the offset, hits on the newest and on an older slot.
    directed_q = '{26'h0000000, 26'h3FFFFFF, 26'h3FF0000, 26'h000FFFF,
                   26'h2AAAAAA, 26'h1555555, 26'h1555555, 26'h0010000,
                   26'h3FF8000, 26'h2AA0001};
    // Single slot: hit keeps the slot, each new block evicts the last one.
    single_q   = '{26'h0050123, 26'h005FFFF, 26'h0060000, 26'h0050000,
                   26'h0050001};

    plan_value = '{10'd1023, 10'd2, 10'd5, 10'd1, 10'd16, 10'd64, 10'd512, 10'd0};
    plan_value[PHASES-1] = CFG_W'($urandom_range(0, 1023));
    plan_items = '{780, 90, 90, 50, 110, 120, 100, 100};

    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    foreach (directed_q[k]) send_item(directed_q[k]);
    // A write of zero behaves as one slot.
    write_slot_count('0);
    foreach (single_q[k]) send_item(single_q[k]);

    for (int p = 0; p < PHASES; p++) begin
      write_slot_count(plan_value[p]);
      eff = (plan_value[p] == 0) ? 1 :
            (plan_value[p] > SLOTS_MAX) ? SLOTS_MAX : plan_value[p];
      pool_size  = eff + $urandom_range(1, eff + 2);
      if (pool_size > BLOCK_COUNT) pool_size = BLOCK_COUNT;
      pool_base  = $urandom_range(0, BLOCK_COUNT - 1);
      stream_blk = $urandom_range(0, BLOCK_COUNT - 1);
      for (int i = 0; i < plan_items[p]; i++) begin
        case ($urandom_range(0, 7))
          0:       low = '0;
          1:       low = '1;
          default: low = 16'($urandom);
        endcase
        if ($urandom_range(0, 99) < 15) begin
          offset = IN_W'($urandom);
        end else begin
          if (p == 0) begin
            // Mostly fresh blocks so the full cache wraps, with recent revisits.
            if ($urandom_range(0, 3) != 0) begin
              stream_blk = (stream_blk + 1) % BLOCK_COUNT;
              blk        = stream_blk;
            end else begin
              blk = (stream_blk + BLOCK_COUNT - $urandom_range(0, 40)) % BLOCK_COUNT;
            end
          end else begin
            // A pool a bit larger than the cache gives both hits and evictions.
            blk = (pool_base + $urandom_range(0, pool_size - 1)) % BLOCK_COUNT;
          end
          offset = {blk[BLK_W-1:0], low};
        end
        send_item(offset);
      end
    end

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Covered %0d items over %0d slot count writes, including 0, 1023 and 512.",
             items_sent, settings_done);
    $display("Results checked %0d: %0d hits, %0d misses, %0d evictions, %0d mismatches.",
             sb.checked_count, items_sent - sb.miss_count, sb.miss_count,
             sb.evict_count, sb.error_count);
    if (sb.error_count == 0) begin
      $display("lru_block_translation_cache_tb: done, clean");
    end else begin
      $display("lru_block_translation_cache_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lbtc_pkg.sv
src/lbtc_map_mem.sv
src/lbtc_slot_mem.sv
src/lbtc_ctrl.sv
src/lru_block_translation_cache.sv
tb/sv/lru_block_translation_cache_tb.sv
